// ===== rtl/tdpb_pkg.sv =====
// Package for the tail drop packet buffer: sizes, time type and shared unit codes.
package tdpb_pkg;

    // Queue storage; the ring index wraps naturally, so DEPTH is a power of two
    localparam int DEPTH     = 1024;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = ADDR_BITS + 1;

    // Field widths
    localparam int TIME_BITS = 32;
    localparam int PROC_BITS = 16;
    localparam int SIZE_BITS = 11;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(1024);
    localparam logic [CNT_BITS-1:0]  CAP_MAX    = CNT_BITS'(DEPTH);

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [CNT_BITS-1:0]  t_count;

    // Operations of the shared add/compare unit
    typedef enum logic {
        ALU_LE,   // flag = (a <= b)
        ALU_ADD   // val = a + b, saturated; flag = carry out
    } t_alu_op;

    typedef struct packed {
        logic  flag;
        t_time val;
    } t_alu_res;

endpackage

// ===== rtl/tdpb_if.sv =====
// Valid/ready channel interfaces for packets, results and the size register.
interface tdpb_pkt_if import tdpb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_time                arrival_ts;
    logic [PROC_BITS-1:0] service_len;

    modport source (output valid, output arrival_ts, output service_len, input ready);
    modport sink   (input valid, input arrival_ts, input service_len, output ready);
endinterface

interface tdpb_res_if import tdpb_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  dropped;
    t_time begin_ts;

    modport source (output valid, output dropped, output begin_ts, input ready);
    modport sink   (input valid, input dropped, input begin_ts, output ready);
endinterface

interface tdpb_cfg_if import tdpb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SIZE_BITS-1:0] buffer_size;

    modport source (output valid, output buffer_size, input ready);
    modport sink   (input valid, input buffer_size, output ready);
endinterface

// ===== rtl/tdpb_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module tdpb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tdpb_alu.sv =====
// Shared adder: unsigned less-or-equal compare and saturating add.
module tdpb_alu import tdpb_pkg::*; (
    input  t_alu_op  i_op,
    input  t_time    i_a,
    input  t_time    i_b,
    output t_alu_res o_res
);

    t_time                x;
    t_time                y;
    logic                 cin;
    logic [TIME_BITS:0]   sum;

    // Compare runs as b - a: carry out means b >= a
    always_comb begin
        case (i_op)
            ALU_LE: begin
                x   = i_b;
                y   = ~i_a;
                cin = 1'b1;
            end
            default: begin
                x   = i_a;
                y   = i_b;
                cin = 1'b0;
            end
        endcase
        sum = {1'b0, x} + {1'b0, y} + {{TIME_BITS{1'b0}}, cin};
    end

    // Saturate the add at the time maximum on carry out
    always_comb begin
        o_res.flag = sum[TIME_BITS];
        if (i_op == ALU_ADD && sum[TIME_BITS]) begin
            o_res.val = '1;
        end else begin
            o_res.val = sum[TIME_BITS-1:0];
        end
    end

endmodule

// ===== rtl/tail_drop_packet_buffer.sv =====
// Top level of the tail drop packet buffer: sequencer, queue state and result register.
//
// A single-server queue model with tail drop. Each packet item carries its arrival
// time and processing time; the block first retires every queued finish time at or
// before the arrival, one entry per cycle through a shared add/compare unit reading
// the finish-time RAM, then either drops the packet (queue at capacity) or reports
// its start time and appends its saturated finish time. The packet channel is not
// ready while an item is at work. The result sits in an output register, so the
// next packet is taken while a result waits; a decision waits until that register
// is free. Capacity is min(buffer_size, 1024); buffer_size is written on the
// configuration channel (always ready) and resets to 1024. No clearing pass is
// needed after reset.
module tail_drop_packet_buffer import tdpb_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tdpb_pkt_if.sink     i_pkt,
    tdpb_res_if.source   o_res,
    tdpb_cfg_if.sink     i_cfg
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RETIRE,
        ST_DECIDE
    } t_state;

    t_state               r_state;
    t_addr                r_head,  n_head;
    t_count               r_count;
    t_time                r_last;
    t_count               r_cap;
    t_time                r_arrival;
    logic [PROC_BITS-1:0] r_proc;
    logic                 r_out_valid, n_out_valid;
    logic                 r_dropped;
    t_time                r_start;

    t_alu_op              alu_op;
    t_time                alu_a;
    t_time                alu_b;
    t_alu_res             alu_res;
    t_time                ram_rdata;
    logic                 ram_we;
    t_addr                tail;
    t_time                start_sel;
    logic                 full;
    logic                 retire;
    logic                 out_free;

    // Queue bookkeeping
    assign full      = (r_count >= r_cap);
    assign tail      = r_head + r_count[ADDR_BITS-1:0];
    assign start_sel = (r_count == '0) ? r_arrival : r_last;
    assign out_free  = !r_out_valid || o_res.ready;
    assign retire    = (r_state == ST_RETIRE) && (r_count != '0) && alu_res.flag;
    assign ram_we    = (r_state == ST_DECIDE) && out_free && !full;
    assign n_head    = retire ? r_head + ADDR_BITS'(1) : r_head;

    // Result register: loaded when a decision issues, cleared once taken
    assign n_out_valid = ((r_state == ST_DECIDE) && out_free)
                      || (r_out_valid && !o_res.ready);

    // Shared unit: head compare while retiring, finish-time add while deciding
    always_comb begin
        if (r_state == ST_DECIDE) begin
            alu_op = ALU_ADD;
            alu_a  = start_sel;
            alu_b  = {{(TIME_BITS-PROC_BITS){1'b0}}, r_proc};
        end else begin
            alu_op = ALU_LE;
            alu_a  = ram_rdata;
            alu_b  = r_arrival;
        end
    end

    tdpb_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // Read address follows the next head, so read data always matches r_head
    tdpb_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tail),
        .i_wdata (alu_res.val),
        .i_raddr (n_head),
        .o_rdata (ram_rdata)
    );

    assign i_pkt.ready    = (r_state == ST_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_res.valid    = r_out_valid;
    assign o_res.dropped  = r_dropped;
    assign o_res.begin_ts = r_start;

    // Sequencer, queue state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_last      <= '0;
            r_cap       <= CAP_MAX;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_cap <= (CNT_BITS'(i_cfg.buffer_size) > CAP_MAX) ? CAP_MAX
                                                                  : CNT_BITS'(i_cfg.buffer_size);
            end
            r_out_valid <= n_out_valid;
            r_head      <= n_head;

            case (r_state)
                ST_IDLE: begin
                    if (i_pkt.valid) begin
                        r_arrival <= i_pkt.arrival_ts;
                        r_proc    <= i_pkt.service_len;
                        r_state   <= ST_RETIRE;
                    end
                end
                ST_RETIRE: begin
                    if (retire) begin
                        r_count <= r_count - CNT_BITS'(1);
                    end else begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                        if (full) begin
                            r_dropped <= 1'b1;
                            r_start   <= '0;
                        end else begin
                            r_dropped <= 1'b0;
                            r_start   <= start_sel;
                            r_last    <= alu_res.val;
                            r_count   <= r_count + CNT_BITS'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/sv/tail_drop_packet_buffer_tb.sv =====
// Self-checking bench for the tail drop packet buffer: directed and random packets, scoreboard.
module tail_drop_packet_buffer_tb import tdpb_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 3;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_CYCLES  = 300;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        t_time                arrival;
        logic [PROC_BITS-1:0] proc;
    } t_pkt_item;

    typedef struct packed {
        logic  dropped;
        t_time start;
    } t_svc_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tdpb_pkt_if pkt_ch ();
    tdpb_res_if res_ch ();
    tdpb_cfg_if cfg_ch ();

    tail_drop_packet_buffer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Packets waiting to be offered, and service results still owed by the block
    t_pkt_item   pkt_backlog[$];
    t_svc_result due_starts[$];

    // Shadow of the queue: finish times, head, occupancy, newest finish, size register
    t_time                finish_mem [DEPTH];
    t_addr                head_ptr      = '0;
    t_count               occupancy     = '0;
    t_time                newest_finish = '0;
    logic [SIZE_BITS-1:0] size_reg      = SIZE_RESET;

    int              send_idle_pct = 28;
    int              recv_idle_pct = 81;
    int              stall_seq     = 0;
    int              stall_seen    = 0;
    int              stall_left    = 0;
    bit              pkt_fire      = 1'b0;
    int              errors        = 0;
    int              cycle_count   = 0;
    longint unsigned arrival_now   = 0;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Retire finished entries, then drop at the tail or enqueue the new finish time
    function automatic t_svc_result serve_packet(t_time arr, logic [PROC_BITS-1:0] proc);
        t_svc_result        r;
        t_count             cap;
        logic [TIME_BITS:0] sum;
        t_addr              tail;
        while (occupancy != 0 && finish_mem[head_ptr] <= arr) begin
            head_ptr  = head_ptr + t_addr'(1);
            occupancy = occupancy - t_count'(1);
        end
        cap = (size_reg > SIZE_BITS'(DEPTH)) ? CAP_MAX : t_count'(size_reg);
        if (occupancy >= cap) begin
            r.dropped = 1'b1;
            r.start   = '0;
            return r;
        end
        r.dropped = 1'b0;
        r.start   = (occupancy == 0) ? arr : newest_finish;
        sum       = {1'b0, r.start} + (TIME_BITS + 1)'(proc);
        tail      = head_ptr + t_addr'(occupancy);
        finish_mem[tail] = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        newest_finish    = finish_mem[tail];
        occupancy        = occupancy + t_count'(1);
        return r;
    endfunction

    // Sample every handshake at the rising edge: size writes, packets in, results out
    always @(posedge i_clk) begin
        t_svc_result want;
        cycle_count = cycle_count + 1;
        pkt_fire    = 1'b0;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) size_reg = cfg_ch.buffer_size;
            if (pkt_ch.valid && pkt_ch.ready) begin
                pkt_fire   = 1'b1;
                want       = serve_packet(pkt_ch.arrival_ts, pkt_ch.service_len);
                due_starts = {due_starts, want};
            end
            if (res_ch.valid && res_ch.ready) begin
                if (due_starts.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected result: dropped=%0b start=%0d",
                                 res_ch.dropped, res_ch.begin_ts);
                end else begin
                    want = due_starts.pop_front();
                    if (res_ch.dropped !== want.dropped || res_ch.begin_ts !== want.start) begin
                        errors = errors + 1;
                        if (errors <= MAX_REPORTS)
                            $display("mismatch: expected dropped=%0b start=%0d, %s%0b start=%0d",
                                     want.dropped, want.start, "got dropped=",
                                     res_ch.dropped, res_ch.begin_ts);
                    end
                end
            end
        end
    end

    // Packet driver: next item once the current one is taken, with random gaps
    always @(negedge i_clk) begin
        t_pkt_item nxt;
        if (!i_rst_n) begin
            pkt_ch.valid <= 1'b0;
        end else if (!pkt_ch.valid || pkt_fire) begin
            if (pkt_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pkt_backlog.pop_front();
                pkt_ch.valid       <= 1'b1;
                pkt_ch.arrival_ts  <= nxt.arrival;
                pkt_ch.service_len <= nxt.proc;
            end else begin
                pkt_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted down here
    always @(negedge i_clk) begin
        if (stall_seq != stall_seen) begin
            stall_seen <= stall_seq;
            stall_left <= STALL_CYCLES;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // Result receiver: random back-pressure
    always @(negedge i_clk) begin
        res_ch.ready <= i_rst_n && stall_left == 0 && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("TB_ERROR");
        $finish;
    end

    task automatic queue_packet(t_time arr, logic [PROC_BITS-1:0] proc);
        t_pkt_item it;
        it.arrival  = arr;
        it.proc     = proc;
        pkt_backlog = {pkt_backlog, it};
    endtask

    // Wait until every packet is in and every result is out
    task automatic settle();
        do @(posedge i_clk);
        while (pkt_backlog.size() != 0 || pkt_ch.valid || due_starts.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_buffer_size(logic [SIZE_BITS-1:0] v);
        @(negedge i_clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.buffer_size <= v;
        do @(posedge i_clk);
        while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One random phase: set size and idling, then a stream of packets on a moving clock
    task automatic run_phase(int send_pct, int recv_pct, logic [SIZE_BITS-1:0] size,
                             int count, int proc_lo, int proc_hi, int gap_hi,
                             bit wild, bit pause_mid, bit hold_off);
        int unsigned     proc;
        int unsigned     pick;
        longint unsigned arr;
        set_buffer_size(size);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        arrival_now   = arrival_now + $urandom_range(0, 1 << 26);
        for (int i = 0; i < count; i++) begin
            if (pause_mid && i == count / 2) settle();
            proc = $urandom_range(proc_lo, proc_hi);
            pick = $urandom_range(0, 99);
            // occasional big jump drains the queue; a few arrivals step backward
            if (wild && pick < 3) arrival_now = arrival_now + $urandom_range(0, 1 << 22);
            else arrival_now = arrival_now + $urandom_range(0, gap_hi);
            arr = arrival_now;
            if (wild && pick >= 3 && pick < 7 && arrival_now > 1000)
                arr = arrival_now - $urandom_range(1, 1000);
            queue_packet(t_time'(arr), PROC_BITS'(proc));
        end
        if (hold_off) stall_seq = stall_seq + 1;
        settle();
    endtask

    initial begin
        pkt_ch.valid       = 1'b0;
        pkt_ch.arrival_ts  = '0;
        pkt_ch.service_len = '0;
        res_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.buffer_size = '0;
        i_rst_n            = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset size: zero times, retire on equal finish, earlier arrival
        queue_packet(32'd0, 16'd0);
        queue_packet(32'd0, 16'hFFFF);
        queue_packet(32'd10, 16'd100);
        queue_packet(32'd5, 16'd1);
        queue_packet(32'd65635, 16'd7);
        settle();
        // Single slot: full queue drops, then frees up
        set_buffer_size(11'd1);
        queue_packet(32'd65636, 16'd3);
        queue_packet(32'd65643, 16'd2);
        settle();
        // Zero capacity drops everything
        set_buffer_size(11'd0);
        queue_packet(32'd70000, 16'd5);
        queue_packet(32'h8000_0000, 16'h1234);
        settle();
        // Size above depth, finish times at and past the top of time
        set_buffer_size(11'h7FF);
        queue_packet(32'hFFFF_FF00, 16'h00FF);
        queue_packet(32'hFFFF_FF00, 16'hFFFF);
        queue_packet(32'hFFFF_FFFE, 16'd1);
        settle();
        // Size lowered below what is queued
        set_buffer_size(11'd2);
        queue_packet(32'hFFFF_FFFE, 16'd9);
        settle();
        // Arrival at the maximum retires all, zero capacity keeps it empty
        set_buffer_size(11'd0);
        queue_packet(32'hFFFF_FFFF, 16'hFFFF);
        settle();

        arrival_now = 0;
        run_phase(28, 81, 11'd1, 60, 0, 65535, 40000, 1'b1, 1'b0, 1'b0);
        run_phase(28, 81, 11'd7, 60, 0, 65535, 8000, 1'b1, 1'b1, 1'b0);
        // Burst at one arrival time fills the whole ring past depth
        run_phase(81, 28, 11'h7FF, 1040, 1, 65535, 0, 1'b0, 1'b0, 1'b0);
        run_phase(81, 28, 11'd3, 50, 0, 65535, 30000, 1'b1, 1'b0, 1'b0);
        run_phase(0, 0, 11'd16, 60, 0, 65535, 2000, 1'b1, 1'b0, 1'b1);
        run_phase(0, 0, 11'd1024, 50, 0, 4000, 3000, 1'b1, 1'b0, 1'b0);
        run_phase(0, 0, 11'd5, 40, 0, 65535, 20000, 1'b1, 1'b0, 1'b0);

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && due_starts.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
